>>> src/wlns_pkg.sv
// ----------------------------------------------------------------------------
// wlns_pkg
// Shared types and constants of the weighted L1 nearest search block.
// ----------------------------------------------------------------------------
package wlns_pkg;

  localparam int unsigned MaxRows   = 256;
  localparam int unsigned MaxSlots  = 64;
  localparam int unsigned MaxDim    = 1024;
  localparam int unsigned ValueBits = 16;
  localparam int unsigned DistBits  = 40;
  localparam int unsigned CfgBits   = 11;

  localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

  typedef enum logic [1:0] {
    MODE_SLOT  = 2'd0,
    MODE_REP   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_SAMPLE_COUNT = 2'd1,
    REG_DIMENSION    = 2'd2,
    REG_NONE         = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PREP  = 2'd1,
    ST_RUN   = 2'd2,
    ST_OUT   = 2'd3
  } state_e;

  // Control handed from the sequencer into the head of the cell chain.
  typedef struct packed {
    logic valid;   // a term enters the chain
    logic first;   // first slot of a row: restart the sum
    logic last;    // last slot of a row: compare the sum
  } term_ctl_t;

endpackage

>>> src/weighted_l1_nearest_search.sv
// ----------------------------------------------------------------------------
// weighted_l1_nearest_search
// Finds the stored row with the least weighted L1 distance to a query.
//
//   channel   dir  handshake            payload
//   in        in   in_valid/in_ready    mode,row,slot,source_index,weight,
//                                       coord_index,value,last
//   out       out  out_valid/out_ready  best_row,best_distance
//   cfg       in   cfg_we_i             cfg_index_i, cfg_data_i
//
// Load items and non-final query words are taken back to back while idle.
// A final query word starts a search: one term per cycle flows through the
// memory reads and a four-cell chain (difference, multiply, accumulate,
// minimum). Input is held off during the search and until the result is
// taken. Reset leaves all stores undefined; configuration resets to one row,
// one slot, dimension one.
// ----------------------------------------------------------------------------
module weighted_l1_nearest_search #(
  parameter int unsigned MAX_ROWS   = wlns_pkg::MaxRows,
  parameter int unsigned MAX_SLOTS  = wlns_pkg::MaxSlots,
  parameter int unsigned MAX_DIM    = wlns_pkg::MaxDim,
  parameter int unsigned VALUE_BITS = wlns_pkg::ValueBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode_i,
  input  logic [7:0]                    row_i,
  input  logic [5:0]                    slot_i,
  input  logic [9:0]                    source_index_i,
  input  logic [15:0]                   weight_i,
  input  logic [9:0]                    coord_index_i,
  input  logic [VALUE_BITS-1:0]         value_i,
  input  logic                          last_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    best_row_o,
  output logic [wlns_pkg::DistBits-1:0] best_distance_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [wlns_pkg::CfgBits-1:0]  cfg_data_i
);

  localparam int unsigned RB  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned SB  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned DB  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned RPB = RB + SB;
  localparam int unsigned DSB = wlns_pkg::DistBits;

  // Configuration, stored as written and clamped to 1..max where it is used
  logic [8:0]  row_count_q;
  logic [6:0]  sample_count_q;
  logic [10:0] dimension_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= 9'd1;
      sample_count_q <= 7'd1;
      dimension_q    <= 11'd1;
    end else if (cfg_we_i) begin
      case (wlns_pkg::reg_e'(cfg_index_i))
        wlns_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data_i[8:0];
        wlns_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[6:0];
        wlns_pkg::REG_DIMENSION:    dimension_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [16:0] rows_eff, slots_eff;
  logic [20:0] dim_eff;
  assign rows_eff  = (row_count_q == '0) ? 17'd1 :
                     (32'(row_count_q) > MAX_ROWS) ? 17'(MAX_ROWS) : 17'(row_count_q);
  assign slots_eff = (sample_count_q == '0) ? 17'd1 :
                     (32'(sample_count_q) > MAX_SLOTS) ? 17'(MAX_SLOTS)
                                                       : 17'(sample_count_q);
  assign dim_eff   = (dimension_q == '0) ? 21'd1 :
                     (32'(dimension_q) > MAX_DIM) ? 21'(MAX_DIM) : 21'(dimension_q);

  wlns_pkg::state_e state_q, state_d;
  logic [RB-1:0] r_q, r_d;
  logic [SB-1:0] s_q, s_d;
  logic [3:0]    drain_q, drain_d;
  logic          issue;
  logic          acc;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_q == wlns_pkg::ST_IDLE);

  // Store writes
  logic slot_we, rep_we, qry_we;
  assign slot_we = acc && mode_i == wlns_pkg::MODE_SLOT && 32'(slot_i) < MAX_SLOTS;
  assign rep_we  = acc && mode_i == wlns_pkg::MODE_REP && 32'(slot_i) < MAX_SLOTS
                   && 32'(row_i) < MAX_ROWS;
  assign qry_we  = acc && mode_i == wlns_pkg::MODE_QUERY && 21'(coord_index_i) < dim_eff;

  // Slot table and representative/query memories
  logic [9:0]            src_rd;
  logic [15:0]           wgt_rd;
  logic [VALUE_BITS-1:0] rep_rd, qry_rd;
  logic [9:0]            src_raddr_q;

  wlns_ram #(.Width(10), .Depth(MAX_SLOTS)) u_src (
    .clk_i, .we_i(slot_we), .waddr_i(SB'(slot_i)), .wdata_i(source_index_i),
    .raddr_i(s_q), .rdata_o(src_rd));
  wlns_ram #(.Width(16), .Depth(MAX_SLOTS)) u_wgt (
    .clk_i, .we_i(slot_we), .waddr_i(SB'(slot_i)), .wdata_i(weight_i),
    .raddr_i(s_q), .rdata_o(wgt_rd));
  wlns_ram #(.Width(VALUE_BITS), .Depth(MAX_ROWS * MAX_SLOTS)) u_rep (
    .clk_i, .we_i(rep_we), .waddr_i(RPB'({RB'(row_i), SB'(slot_i)})), .wdata_i(value_i),
    .raddr_i({r_q, s_q}), .rdata_o(rep_rd));
  wlns_ram #(.Width(VALUE_BITS), .Depth(MAX_DIM)) u_qry (
    .clk_i, .we_i(qry_we), .waddr_i(DB'(coord_index_i)), .wdata_i(value_i),
    .raddr_i(DB'(src_rd)), .rdata_o(qry_rd));

  // Sequencer
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    s_d     = s_q;
    drain_d = drain_q;
    issue   = 1'b0;
    case (state_q)
      wlns_pkg::ST_IDLE: begin
        r_d = '0;
        s_d = '0;
        if (acc && mode_i == wlns_pkg::MODE_QUERY && last_i) begin
          state_d = wlns_pkg::ST_PREP;
        end
      end
      wlns_pkg::ST_PREP: begin
        issue = 1'b1;
        if (17'(s_q) + 17'd1 == slots_eff) begin
          s_d = '0;
          if (17'(r_q) + 17'd1 == rows_eff) begin
            state_d = wlns_pkg::ST_RUN;
            drain_d = 4'd7;
          end else begin
            r_d = r_q + 1'b1;
          end
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      wlns_pkg::ST_RUN: begin
        drain_d = drain_q - 4'd1;
        if (drain_q == 4'd1) begin
          state_d = wlns_pkg::ST_OUT;
        end
      end
      default: begin
        if (out_ready) begin
          state_d = wlns_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wlns_pkg::ST_IDLE;
      r_q     <= '0;
      s_q     <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      s_q     <= s_d;
      drain_q <= drain_d;
    end
  end

  // Align control with read data: ctl_p1_q for the slot table and rep reads, ctl_p2_q
  // for the query read addressed by the slot table; rep_p2_q holds the rep value to meet it
  wlns_pkg::term_ctl_t ctl_p1_q, ctl_p2_q;
  logic [RB-1:0]       row_p1_q, row_p2_q;
  logic [15:0]         wgt_p2_q;
  logic                qok_p2_q;
  logic [15:0]         wgt_p3_q;
  logic [VALUE_BITS-1:0] rep_p2_q;
  wlns_pkg::term_ctl_t ctl_now;

  assign ctl_now.valid = issue;
  assign ctl_now.first = issue && s_q == '0;
  assign ctl_now.last  = issue && 17'(s_q) + 17'd1 == slots_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_p1_q <= '0;
      ctl_p2_q <= '0;
    end else begin
      ctl_p1_q <= ctl_now;
      ctl_p2_q <= ctl_p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row_p1_q <= r_q;
    row_p2_q <= row_p1_q;
    wgt_p2_q <= wgt_rd;
    qok_p2_q <= 21'(src_rd) < dim_eff;
    wgt_p3_q <= wgt_p2_q;
    rep_p2_q <= rep_rd;
  end

  logic [VALUE_BITS-1:0] q_val;
  assign q_val = qok_p2_q ? qry_rd : '0;

  // Cell chain
  wlns_pkg::term_ctl_t ctl_c0, ctl_c1, ctl_c2, ctl_c3, ctl_acc;
  logic [DSB-1:0] d_c0, d_c1, d_c2, d_c3;
  logic [RB-1:0]  row_c0, row_c1, row_c2, row_c3, best_unused0, best_unused1,
                  best_unused2, best_r;
  logic [DSB-1:0] aux1;

  assign aux1 = DSB'(wgt_p3_q);

  wlns_cell #(.Kind(0), .ValueBits(VALUE_BITS), .RowBits(RB)) u_c0 (
    .clk_i, .rst_ni, .ctl_i(ctl_p2_q), .data_i(DSB'(q_val)), .aux_i(DSB'(rep_p2_q)),
    .row_i(row_p2_q), .ctl_o(ctl_c0), .data_o(d_c0), .row_o(row_c0),
    .best_row_o(best_unused0));
  wlns_cell #(.Kind(1), .ValueBits(VALUE_BITS), .RowBits(RB)) u_c1 (
    .clk_i, .rst_ni, .ctl_i(ctl_c0), .data_i(d_c0), .aux_i(aux1),
    .row_i(row_c0), .ctl_o(ctl_c1), .data_o(d_c1), .row_o(row_c1),
    .best_row_o(best_unused1));
  wlns_cell #(.Kind(2), .ValueBits(VALUE_BITS), .RowBits(RB)) u_c2 (
    .clk_i, .rst_ni, .ctl_i(ctl_c1), .data_i(d_c1), .aux_i('0),
    .row_i(row_c1), .ctl_o(ctl_c2), .data_o(d_c2), .row_o(row_c2),
    .best_row_o(best_unused2));

  // Only finished row sums go into the minimum cell
  always_comb begin
    ctl_acc       = ctl_c2;
    ctl_acc.valid = ctl_c2.valid && ctl_c2.last;
    ctl_acc.first = ctl_c2.valid && ctl_c2.last && row_c2 == '0;
  end

  wlns_cell #(.Kind(3), .ValueBits(VALUE_BITS), .RowBits(RB)) u_c3 (
    .clk_i, .rst_ni, .ctl_i(ctl_acc), .data_i(d_c2), .aux_i('0),
    .row_i(row_c2), .ctl_o(ctl_c3), .data_o(d_c3), .row_o(row_c3),
    .best_row_o(best_r));

  assign out_valid       = (state_q == wlns_pkg::ST_OUT);
  assign best_row_o      = 8'(best_r);
  assign best_distance_o = d_c3;

`ifndef SYNTH
  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != wlns_pkg::ST_IDLE |-> !in_ready)
    else $error("input taken during search");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(best_distance_o))
    else $error("result changed while stalled");
  a_chain_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !ctl_p1_q.valid && !ctl_c2.valid)
    else $error("terms in flight at result");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(issue) |-> r_q == '0 && s_q == '0)
    else $error("search not started at row zero");
`endif

endmodule

>>> src/wlns_ram.sv
// ----------------------------------------------------------------------------
// wlns_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wlns_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/wlns_cell.sv
// ----------------------------------------------------------------------------
// wlns_cell
// One stage of the distance chain. Stage 0 takes the difference magnitude,
// stage 1 multiplies by the weight, stage 2 accumulates a row sum with
// saturation, stage 3 keeps the running minimum. Each cell passes its term
// and control to the neighbor every cycle.
// ----------------------------------------------------------------------------
module wlns_cell #(
  parameter int unsigned Kind      = 0,
  parameter int unsigned ValueBits = wlns_pkg::ValueBits,
  parameter int unsigned RowBits   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wlns_pkg::term_ctl_t           ctl_i,
  input  logic [wlns_pkg::DistBits-1:0] data_i,
  input  logic [wlns_pkg::DistBits-1:0] aux_i,
  input  logic [RowBits-1:0]            row_i,
  output wlns_pkg::term_ctl_t           ctl_o,
  output logic [wlns_pkg::DistBits-1:0] data_o,
  output logic [RowBits-1:0]            row_o,
  output logic [RowBits-1:0]            best_row_o
);

  localparam int unsigned DB = wlns_pkg::DistBits;

  wlns_pkg::term_ctl_t ctl_q;
  logic [DB-1:0]       data_q, data_d;
  logic [RowBits-1:0]  row_q;
  logic [RowBits-1:0]  best_q, best_d;
  logic signed [ValueBits:0] diff;
  logic [ValueBits+16:0] prod;
  logic [DB:0]         sum;

  // Work on the incoming term
  always_comb begin
    data_d = data_q;
    best_d = best_q;
    diff   = '0;
    prod   = '0;
    sum    = '0;
    case (Kind)
      0: begin
        diff   = $signed({data_i[ValueBits-1], data_i[ValueBits-1:0]})
               - $signed({aux_i[ValueBits-1], aux_i[ValueBits-1:0]});
        data_d = DB'(diff[ValueBits] ? -diff : diff);
      end
      1: begin
        prod   = data_i[ValueBits:0] * aux_i[15:0];
        data_d = DB'(prod);
      end
      2: begin
        if (ctl_i.valid) begin
          sum    = {1'b0, (ctl_i.first ? '0 : data_q)} + {1'b0, data_i};
          data_d = sum[DB] ? wlns_pkg::DistMax : sum[DB-1:0];
        end
      end
      default: begin
        if (ctl_i.valid && (ctl_i.first || data_i < data_q)) begin
          data_d = data_i;
          best_d = row_i;
        end
      end
    endcase
  end

  // Hand the term to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    row_q  <= row_i;
    best_q <= best_d;
  end

  assign ctl_o      = ctl_q;
  assign data_o     = data_q;
  assign row_o      = row_q;
  assign best_row_o = best_q;

endmodule
